// File: rtl/msap_pkg.sv
`default_nettype none
package msap_pkg;

  localparam int unsigned MAX_WINDOW = 16;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned SUM_W = 64;
  localparam int unsigned CFG_W = 5;
  // Index of a cell, and a count that can hold MAX_WINDOW itself.
  localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned LIM_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PROD_W = ELEM_W + LIM_W + 1;

  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  typedef struct packed {
    logic load;
    logic prod;
    logic cand;
    logic scan;
    logic commit;
    logic clear;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/msap_cell.sv
`default_nettype none
module msap_cell (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire msap_pkg::cell_ctrl_t                  ctrl_i,
  input  wire logic        [msap_pkg::IDX_W-1:0]     idx_i,
  input  wire logic        [msap_pkg::LIM_W-1:0]     lim_i,
  input  wire logic signed [msap_pkg::ELEM_W-1:0]    elem_i,
  input  wire logic signed [msap_pkg::ELEM_W-1:0]    max_prev_i,
  input  wire logic signed [msap_pkg::SUM_W-1:0]     prefix_prev_i,
  input  wire logic signed [msap_pkg::SUM_W-1:0]     cand_next_i,
  output logic signed      [msap_pkg::ELEM_W-1:0]    max_o,
  output logic signed      [msap_pkg::SUM_W-1:0]     prefix_o,
  output logic signed      [msap_pkg::SUM_W-1:0]     cand_o
);

  logic signed [msap_pkg::ELEM_W-1:0] max_q;
  logic signed [msap_pkg::SUM_W-1:0]  prefix_q;
  logic signed [msap_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [msap_pkg::SUM_W-1:0]  cand_q, cand_d;
  logic        [msap_pkg::LIM_W-1:0]  len;
  logic        [msap_pkg::SUM_W:0]    sum_wide;
  logic                               in_window;

  // This cell covers the piece of the newest idx+1 elements.
  assign len       = msap_pkg::LIM_W'(idx_i) + msap_pkg::LIM_W'(1);
  assign in_window = msap_pkg::LIM_W'(idx_i) < lim_i;
  assign prod_d    = msap_pkg::PROD_W'(max_q) * msap_pkg::PROD_W'($signed({1'b0, len}));

  assign sum_wide = {prefix_q[msap_pkg::SUM_W-1], prefix_q}
                  + {{(msap_pkg::SUM_W + 1 - msap_pkg::PROD_W){prod_q[msap_pkg::PROD_W-1]}},
                     prod_q};

  always_comb begin
    if (!in_window) begin
      cand_d = msap_pkg::SUM_MIN;
    end else if (sum_wide[msap_pkg::SUM_W] != sum_wide[msap_pkg::SUM_W-1]) begin
      cand_d = sum_wide[msap_pkg::SUM_W] ? msap_pkg::SUM_MIN : msap_pkg::SUM_MAX;
    end else begin
      cand_d = sum_wide[msap_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= '0;
      prefix_q <= '0;
    end else if (ctrl_i.commit && ctrl_i.clear) begin
      max_q    <= '0;
      prefix_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        max_q <= (max_prev_i > elem_i) ? max_prev_i : elem_i;
      end
      if (ctrl_i.commit) begin
        prefix_q <= prefix_prev_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.cand) begin
      cand_q <= cand_d;
    end else if (ctrl_i.scan) begin
      cand_q <= cand_next_i;
    end
  end

  assign max_o    = max_q;
  assign prefix_o = prefix_q;
  assign cand_o   = cand_q;

endmodule
`default_nettype wire

// File: rtl/max_sum_array_partition_unit.sv
// An element is taken in ST_IDLE and passes ST_PROD, ST_CAND and ST_SCAN; in ST_DONE its result
// beat is registered. The input stalls until then, the scan being set by the candidate totals
// draining one cell per cycle through the chain into the running maximum.
// A finished result waits in the output register; the next element is taken meanwhile.
// Reset clears cell maxima and prefixes, the element count and the output; window_q resets to 1.
`default_nettype none
module max_sum_array_partition_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic        [msap_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [msap_pkg::ELEM_W-1:0] element_value_i,
  input  wire logic                               last_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed      [msap_pkg::SUM_W-1:0]  best_sum_o,
  output logic                                    final_result_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_CAND,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                             state_q;
  logic [msap_pkg::CFG_W-1:0]         window_q;
  logic [msap_pkg::LIM_W-1:0]         seen_q;
  logic [msap_pkg::LIM_W-1:0]         lim_q, lim_d;
  logic [msap_pkg::LIM_W-1:0]         k_eff;
  logic [msap_pkg::LIM_W:0]           avail;
  logic [msap_pkg::IDX_W-1:0]         cnt_q;
  logic                               last_q;
  logic signed [msap_pkg::SUM_W-1:0]  best_q;
  logic                               out_valid_q;
  logic                               out_free;
  logic                               in_take;
  msap_pkg::cell_ctrl_t               ctrl;

  logic signed [msap_pkg::ELEM_W-1:0] max_w    [msap_pkg::MAX_WINDOW];
  logic signed [msap_pkg::SUM_W-1:0]  prefix_w [msap_pkg::MAX_WINDOW];
  logic signed [msap_pkg::SUM_W-1:0]  cand_w   [msap_pkg::MAX_WINDOW];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // A limit of zero acts as one; a limit past the chain length acts as the full chain.
  always_comb begin
    if (window_q == '0) begin
      k_eff = msap_pkg::LIM_W'(1);
    end else if (32'(window_q) > 32'(msap_pkg::MAX_WINDOW)) begin
      k_eff = msap_pkg::LIM_W'(msap_pkg::MAX_WINDOW);
    end else begin
      k_eff = msap_pkg::LIM_W'(window_q);
    end
    avail = {1'b0, seen_q} + (msap_pkg::LIM_W + 1)'(1);
    lim_d = ({1'b0, k_eff} < avail) ? k_eff : avail[msap_pkg::LIM_W-1:0];
  end

  always_comb begin
    ctrl        = '0;
    ctrl.load   = in_take;
    ctrl.prod   = (state_q == ST_PROD);
    ctrl.cand   = (state_q == ST_CAND);
    ctrl.scan   = (state_q == ST_SCAN);
    ctrl.commit = (state_q == ST_DONE) && out_free;
    ctrl.clear  = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= msap_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      lim_q       <= '0;
      best_q      <= msap_pkg::SUM_MIN;
      best_sum_o  <= '0;
      final_result_o <= 1'b0;
    end else begin
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            lim_q   <= lim_d;
            last_q  <= last_item_i;
            best_q  <= msap_pkg::SUM_MIN;
            state_q <= ST_PROD;
          end
        end
        ST_PROD: begin
          state_q <= ST_CAND;
        end
        ST_CAND: begin
          cnt_q   <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          // Cell 0 presents one candidate per cycle as the chain drains toward it.
          if (cand_w[0] > best_q) begin
            best_q <= cand_w[0];
          end
          cnt_q <= cnt_q + msap_pkg::IDX_W'(1);
          if (cnt_q == msap_pkg::IDX_W'(msap_pkg::MAX_WINDOW - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            best_sum_o     <= best_q;
            final_result_o <= last_q;
            if (last_q) begin
              seen_q <= '0;
            end else if (32'(seen_q) < 32'(msap_pkg::MAX_WINDOW)) begin
              seen_q <= seen_q + msap_pkg::LIM_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  for (genvar g = 0; g < msap_pkg::MAX_WINDOW; g++) begin : g_cell
    logic signed [msap_pkg::ELEM_W-1:0] max_prev;
    logic signed [msap_pkg::SUM_W-1:0]  prefix_prev;
    logic signed [msap_pkg::SUM_W-1:0]  cand_next;

    if (g == 0) begin : g_head
      assign max_prev    = element_value_i;
      assign prefix_prev = best_q;
    end else begin : g_body
      assign max_prev    = max_w[g-1];
      assign prefix_prev = prefix_w[g-1];
    end

    if (g == msap_pkg::MAX_WINDOW - 1) begin : g_tail
      assign cand_next = msap_pkg::SUM_MIN;
    end else begin : g_link
      assign cand_next = cand_w[g+1];
    end

    msap_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .idx_i         (msap_pkg::IDX_W'(g)),
      .lim_i         (lim_q),
      .elem_i        (element_value_i),
      .max_prev_i    (max_prev),
      .prefix_prev_i (prefix_prev),
      .cand_next_i   (cand_next),
      .max_o         (max_w[g]),
      .prefix_o      (prefix_w[g]),
      .cand_o        (cand_w[g])
    );
  end

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [msap_pkg::ELEM_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [msap_pkg::ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;
  localparam int unsigned RANDOM_ELEMENTS = 1820;
  localparam int unsigned LONG_HOLD = 400;

  typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_e;
  typedef enum logic [1:0] {VAL_FULL, VAL_SMALL, VAL_EXTREME, VAL_FLAT} val_style_e;

  // Tracks the expected best partition totals, one per element beat.
  class partition_sum_tracker;
    typedef struct {
      longint best;
      logic   fin;
    } sum_beat_t;

    logic [msap_pkg::CFG_W-1:0] window;
    longint           piece_max [msap_pkg::MAX_WINDOW];
    longint           prefix_best [msap_pkg::MAX_WINDOW];
    int unsigned      seen;
    sum_beat_t        expected_sums [$];
    int               errors;
    int               compared;
    int               elements;
    int               arrays;

    function new();
      window = 1;
      clear_array();
    endfunction

    function void clear_array();
      foreach (piece_max[d]) begin
        piece_max[d] = 0;
        prefix_best[d] = 0;
      end
      seen = 0;
    endfunction

    function void set_window(logic [msap_pkg::CFG_W-1:0] v);
      window = v;
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    static function longint sat_sum(longint a, longint b);
      logic signed [msap_pkg::SUM_W:0] wide;
      wide = $signed({a[msap_pkg::SUM_W-1], a}) + $signed({b[msap_pkg::SUM_W-1], b});
      if (wide > $signed({1'b0, msap_pkg::SUM_MAX})) return msap_pkg::SUM_MAX;
      if (wide < $signed({1'b1, msap_pkg::SUM_MIN})) return msap_pkg::SUM_MIN;
      return wide[msap_pkg::SUM_W-1:0];
    endfunction

    function void note_element(logic signed [msap_pkg::ELEM_W-1:0] elem, logic last);
      longint      x;
      longint      best;
      longint      cand;
      int unsigned k;
      int unsigned lim;
      sum_beat_t   beat;
      x = elem;
      k = window;
      if (k < 1) k = 1;
      if (k > msap_pkg::MAX_WINDOW) k = msap_pkg::MAX_WINDOW;
      // Entry d holds the largest of the newest d+1 elements.
      for (int d = msap_pkg::MAX_WINDOW - 1; d > 0; d--) begin
        piece_max[d] = (piece_max[d-1] > x) ? piece_max[d-1] : x;
      end
      piece_max[0] = x;
      lim = (k < seen + 1) ? k : seen + 1;
      best = msap_pkg::SUM_MIN;
      for (int d = 0; d < lim; d++) begin
        cand = sat_sum(prefix_best[d], longint'(d + 1) * piece_max[d]);
        if (cand > best) best = cand;
      end
      for (int d = msap_pkg::MAX_WINDOW - 1; d > 0; d--) begin
        prefix_best[d] = prefix_best[d-1];
      end
      prefix_best[0] = best;
      if (seen < msap_pkg::MAX_WINDOW) seen++;
      beat.best = best;
      beat.fin = last;
      expected_sums.push_back(beat);
      elements++;
      if (last) begin
        arrays++;
        clear_array();
      end
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      if (errors <= 20) begin
        $display("mismatch at result %0d: %s is %0d, want %0d", compared, what, got, want);
      end
    endtask

    task check_result(logic signed [msap_pkg::SUM_W-1:0] got_sum, logic got_final);
      sum_beat_t want;
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected result beat, best_sum", got_sum, 0);
        return;
      end
      want = expected_sums.pop_front();
      compared++;
      if (got_sum !== want.best) report_mismatch("best_sum", got_sum, want.best);
      if (got_final !== want.fin) report_mismatch("final_result", got_final, want.fin);
    endtask
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_we_i = 1'b0;
  logic [msap_pkg::CFG_W-1:0]         cfg_wdata_i = '0;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic signed [msap_pkg::ELEM_W-1:0] element_value_i = '0;
  logic                               last_item_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic signed [msap_pkg::SUM_W-1:0]  best_sum_o;
  logic                               final_result_o;

  partition_sum_tracker sb;
  int                   burst_left = 0;
  bit                   steady_sender = 1'b0;
  int                   offered = 0;
  int                   hold_trigger = 0;
  bit [31:0]            windows_used = '0;

  max_sum_array_partition_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_value_i(element_value_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .best_sum_o     (best_sum_o),
    .final_result_o (final_result_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_window(cfg_wdata_i);
      if (in_valid_i && !in_stall_o) sb.note_element(element_value_i, last_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(best_sum_o, final_result_o);
    end
  end

  // The receiver changes its stall pattern now and then; a long hold-off
  // is requested by bumping hold_trigger.
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_step = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  always @(negedge clk_i) begin
    if (hold_seen != hold_trigger) begin
      hold_seen = hold_trigger;
      hold_left = LONG_HOLD;
    end
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(50, 600);
    end
    rx_mode_left--;
    rx_step++;
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_OPEN:     out_stall_i = 1'b0;
        RX_SPARSE:   out_stall_i = ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_stall_i = ((rx_step % 9) < 4);
        default:     out_stall_i = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic logic signed [msap_pkg::ELEM_W-1:0] next_value(
      val_style_e style, logic signed [msap_pkg::ELEM_W-1:0] flat);
    case (style)
      VAL_FULL:  return $urandom;
      VAL_SMALL: return int'($urandom_range(0, 40)) - 20;
      VAL_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return ELEM_MIN;
          1:       return ELEM_MAX;
          2:       return 0;
          3:       return -1;
          4:       return 1;
          default: return ELEM_MIN + 1;
        endcase
      end
      default:   return flat;
    endcase
  endfunction

  task automatic send_element(input logic signed [msap_pkg::ELEM_W-1:0] v, input logic last);
    int gap;
    int r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      r = $urandom_range(0, 9);
      if (steady_sender) gap = 0;
      else if (r < 5) gap = $urandom_range(0, 3);
      else if (r < 8) gap = $urandom_range(4, 20);
      else gap = $urandom_range(21, 40);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        element_value_i = $urandom;
        last_item_i = $urandom_range(0, 1);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    element_value_i = v;
    last_item_i = last;
    do @(posedge clk_i); while (in_stall_o);
    offered++;
  endtask

  task automatic send_array(input int len, input bit close);
    val_style_e                         style;
    logic signed [msap_pkg::ELEM_W-1:0] flat;
    style = val_style_e'($urandom_range(0, 3));
    flat = $urandom;
    for (int i = 0; i < len; i++) begin
      send_element(next_value(style, flat), close && (i == len - 1));
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_window(input logic [msap_pkg::CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    windows_used[v] = 1'b1;
  endtask

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int                         phase;
    int                         phase_target;
    int                         len;
    int                         r;
    bit                         close;
    logic [msap_pkg::CFG_W-1:0] w;
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Window of one straight out of reset.
    send_element(5, 1'b0);
    send_element(-3, 1'b0);
    send_element(7, 1'b1);
    drain_results();
    write_window(16);
    send_element(ELEM_MAX, 1'b0);
    send_element(ELEM_MIN, 1'b0);
    send_element(ELEM_MAX, 1'b1);
    send_element(ELEM_MIN, 1'b1);
    send_element(-1, 1'b0);
    send_element(0, 1'b0);
    send_element(1, 1'b0);
    send_element(-1, 1'b1);
    drain_results();
    // A zero window behaves as a window of one.
    write_window(0);
    send_element(4, 1'b0);
    send_element(9, 1'b1);
    drain_results();
    // Values above the cell count clamp to the full depth.
    write_window(31);
    for (int i = 1; i <= 5; i++) send_element((i < 4) ? i : 6 - i, i == 5);
    drain_results();
    // Narrow the window in the middle of an array.
    write_window(3);
    send_element(10, 1'b0);
    send_element(-20, 1'b0);
    send_element(30, 1'b0);
    drain_results();
    write_window(1);
    send_element(40, 1'b0);
    send_element(-50, 1'b1);
    drain_results();
    write_window(17);
    send_element(ELEM_MAX, 1'b0);
    send_element(ELEM_MAX, 1'b1);

    phase = 0;
    while (offered < RANDOM_ELEMENTS) begin
      // Every expected result is back before the window moves.
      drain_results();
      case ($urandom_range(0, 6))
        0:       w = 0;
        1:       w = 1;
        2:       w = 2;
        3:       w = 16;
        4:       w = 17;
        5:       w = 31;
        default: w = $urandom_range(0, 31);
      endcase
      write_window(w);
      phase_target = offered + $urandom_range(60, 160);
      if (phase == 2) begin
        // Hold the receiver off while elements keep coming back to back.
        steady_sender = 1'b1;
        hold_trigger++;
      end
      while (offered < phase_target) begin
        r = $urandom_range(0, 19);
        if (r < 14) len = $urandom_range(1, 20);
        else if (r < 19) len = $urandom_range(17, 40);
        else len = 1;
        close = !((offered + len >= phase_target) && ($urandom_range(0, 3) == 0));
        send_array(len, close);
      end
      steady_sender = 1'b0;
      phase++;
    end

    drain_results();
    repeat (msap_pkg::MAX_WINDOW + 8) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("results never delivered", sb.pending(), 0);
    $display("Run fed %0d elements (%0d closed arrays) over %0d window phases.",
             sb.elements, sb.arrays, phase);
    $display("Compared %0d result beats under %0d distinct window settings.",
             sb.compared, $countones(windows_used));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
